// ===== rtl/bmg_pkg.sv =====
package bmg_pkg;

    // Register indexes on the configuration port
    localparam logic CFG_MEAN = 1'b0;
    localparam logic CFG_STD  = 1'b1;

    localparam int LOG_STEPS    = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;  // signed width of x, y and z
    localparam int MAG_W        = 32;  // magnitude of the trig term
    localparam int MAG2_W       = 33;  // radius times trig term, Q28
    localparam int BIG_W        = 36;  // scaled term, Q16
    localparam int SUM_W        = 38;  // mean plus scaled term

    localparam logic [27:0] TWO_LN2_Q27     = 28'd186065279;
    localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // arctan(2^-i) in Q30
    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] v;
        case (idx)
            0:  v = 30'd843314856;
            1:  v = 30'd497837829;
            2:  v = 30'd263043836;
            3:  v = 30'd133525158;
            4:  v = 30'd67021686;
            5:  v = 30'd33543515;
            6:  v = 30'd16775850;
            7:  v = 30'd8388437;
            8:  v = 30'd4194282;
            9:  v = 30'd2097149;
            10: v = 30'd1048575;
            11: v = 30'd524287;
            12: v = 30'd262143;
            13: v = 30'd131071;
            14: v = 30'd65535;
            15: v = 30'd32767;
            16: v = 30'd16383;
            17: v = 30'd8191;
            18: v = 30'd4095;
            19: v = 30'd2047;
            20: v = 30'd1023;
            21: v = 30'd511;
            22: v = 30'd255;
            23: v = 30'd127;
            24: v = 30'd63;
            25: v = 30'd31;
            26: v = 30'd15;
            27: v = 30'd7;
            28: v = 30'd3;
            default: v = 30'd1;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/bmg_log2.sv =====
// -log2((2^UB - u1) / 2^UB) in Q30: normalize, then one squaring per stage
module bmg_log2 #(
    parameter int UNIFORM_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic [UNIFORM_BITS-1:0]               i_u1,
    output logic                                  o_vld,
    output logic [$clog2(UNIFORM_BITS+1)+29:0]    o_t
);
    localparam int W  = UNIFORM_BITS + 1;
    localparam int CW = $clog2(W);
    localparam int NW = (W > 31) ? W : 31;
    localparam int TW = CW + 30;
    localparam int NS = bmg_pkg::LOG_STEPS;

    logic [W-1:0]    w_x;
    logic [NW-1:0]   r_nv   [0:CW];
    logic [CW-1:0]   r_cnt  [0:CW];
    logic            r_nvld [0:CW];
    logic [30:0]     r_m    [1:NS];
    logic [29:0]     r_fr   [1:NS];
    logic [CW-1:0]   r_sc   [1:NS];
    logic            r_svld [1:NS];
    logic [TW-1:0]   r_t;
    logic            r_tvld;

    assign w_x = (W'(1) << UNIFORM_BITS) - W'(i_u1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvld[0] <= 1'b0;
        end else if (i_en) begin
            r_nvld[0] <= i_vld;
        end
        if (i_en) begin
            r_nv[0]  <= NW'(w_x) << (NW - W);
            r_cnt[0] <= '0;
        end
    end

    // binary search for the leading one, widest shift first
    for (genvar j = 1; j <= CW; j++) begin : g_norm
        localparam int SH = 1 << (CW - j);
        logic w_zero;
        assign w_zero = (r_nv[j-1][NW-1 -: SH] == '0);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nvld[j] <= 1'b0;
            end else if (i_en) begin
                r_nvld[j] <= r_nvld[j-1];
            end
            if (i_en) begin
                r_nv[j]  <= w_zero ? (r_nv[j-1] << SH) : r_nv[j-1];
                r_cnt[j] <= r_cnt[j-1] + (w_zero ? CW'(SH) : CW'(0));
            end
        end
    end

    for (genvar s = 1; s <= NS; s++) begin : g_sq
        logic [30:0]   w_mi;
        logic [29:0]   w_fi;
        logic [CW-1:0] w_ci;
        logic          w_vi;
        logic [61:0]   w_sq;
        logic [31:0]   w_q;
        if (s == 1) begin : g_first
            assign w_mi = r_nv[CW][NW-1 -: 31];
            assign w_fi = '0;
            assign w_ci = r_cnt[CW];
            assign w_vi = r_nvld[CW];
        end else begin : g_next
            assign w_mi = r_m[s-1];
            assign w_fi = r_fr[s-1];
            assign w_ci = r_sc[s-1];
            assign w_vi = r_svld[s-1];
        end
        assign w_sq = w_mi * w_mi;
        assign w_q  = w_sq[61:30];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_svld[s] <= 1'b0;
            end else if (i_en) begin
                r_svld[s] <= w_vi;
            end
            if (i_en) begin
                r_m[s]  <= w_q[31] ? w_q[31:1] : w_q[30:0];
                r_fr[s] <= w_fi | (w_q[31] ? (30'(1) << (30 - s)) : 30'(0));
                r_sc[s] <= w_ci;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvld <= 1'b0;
        end else if (i_en) begin
            r_tvld <= r_svld[NS];
        end
        if (i_en) begin
            r_t <= (TW'(r_sc[NS]) << 30) - TW'(r_fr[NS]);
        end
    end

    assign o_vld = r_tvld;
    assign o_t   = r_t;

endmodule

// ===== rtl/bmg_sqrt.sv =====
// Floor square root of (rsq << 18), one result bit per stage
module bmg_sqrt #(
    parameter int RSQ_W = 37
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_en,
    input  logic                                            i_vld,
    input  logic [RSQ_W-1:0]                                i_rsq,
    output logic                                            o_vld,
    output logic [(RSQ_W + 18 + ((RSQ_W + 18) % 2))/2-1:0]  o_root
);
    localparam int SV = RSQ_W + 18;
    localparam int SW = SV + (SV % 2);
    localparam int NI = SW / 2;

    logic [SW-1:0] r_v   [0:NI];
    logic [SW-1:0] r_r   [0:NI];
    logic          r_vld [0:NI];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
        if (i_en) begin
            r_v[0] <= SW'(i_rsq) << 18;
            r_r[0] <= '0;
        end
    end

    for (genvar i = 1; i <= NI; i++) begin : g_bit
        localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 * i);
        logic [SW-1:0] w_rb;
        logic          w_ge;
        assign w_rb = r_r[i-1] + BIT;
        assign w_ge = (r_v[i-1] >= w_rb);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= r_vld[i-1];
            end
            if (i_en) begin
                r_v[i] <= w_ge ? (r_v[i-1] - w_rb) : r_v[i-1];
                r_r[i] <= w_ge ? ((r_r[i-1] >> 1) + BIT) : (r_r[i-1] >> 1);
            end
        end
    end

    assign o_vld  = r_vld[NI];
    assign o_root = r_r[NI][NI-1:0];

endmodule

// ===== rtl/bmg_cordic.sv =====
// Quadrant split, angle scaling and rotation-mode CORDIC, one step per stage
module bmg_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [31:0]                          i_ang,
    input  logic                                 i_pick,
    output logic signed [bmg_pkg::CORDIC_W-1:0]  o_cos,
    output logic signed [bmg_pkg::CORDIC_W-1:0]  o_sin,
    output logic [1:0]                           o_quad,
    output logic                                 o_pick
);
    localparam int XW = bmg_pkg::CORDIC_W;
    localparam int NS = bmg_pkg::CORDIC_STEPS;

    logic [61:0]          w_th;
    logic signed [XW-1:0] r_x    [0:NS];
    logic signed [XW-1:0] r_y    [0:NS];
    logic signed [XW-1:0] r_z    [0:NS];
    logic [1:0]           r_quad [0:NS];
    logic                 r_pick [0:NS];

    assign w_th = i_ang[29:0] * bmg_pkg::HALF_PI_Q30 + (62'(1) << 29);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= $signed(XW'(bmg_pkg::CORDIC_GAIN_Q30));
            r_y[0]    <= '0;
            r_z[0]    <= $signed(XW'(w_th[61:30]));
            r_quad[0] <= i_ang[31:30];
            r_pick[0] <= i_pick;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_step
        localparam logic signed [XW-1:0] ATAN = $signed(XW'(bmg_pkg::atan_q30(i)));
        logic signed [XW-1:0] w_xs;
        logic signed [XW-1:0] w_ys;
        assign w_xs = r_x[i] >>> i;
        assign w_ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][XW-1]) begin
                    r_x[i+1] <= r_x[i] - w_ys;
                    r_y[i+1] <= r_y[i] + w_xs;
                    r_z[i+1] <= r_z[i] - ATAN;
                end else begin
                    r_x[i+1] <= r_x[i] + w_ys;
                    r_y[i+1] <= r_y[i] - w_xs;
                    r_z[i+1] <= r_z[i] + ATAN;
                end
                r_quad[i+1] <= r_quad[i];
                r_pick[i+1] <= r_pick[i];
            end
        end
    end

    assign o_cos  = r_x[NS];
    assign o_sin  = r_y[NS];
    assign o_quad = r_quad[NS];
    assign o_pick = r_pick[NS];

endmodule

// ===== rtl/box_muller_gaussian_core.sv =====
// Box-Muller gaussian sample generator.
// Input stream: each word carries two uniform fractions in tdata (radius
// uniform in the low UNIFORM_BITS, angle uniform above it) and the sine/cosine
// pick in tuser. Output stream: the signed Q16.16 sample in tdata and the
// saturation flag in tuser. Mean and standard deviation sit on a plain write
// port; the user must change them only while no word is in flight, since the
// block does not enforce it. Throughput: one word per clock unless the
// receiver stalls. The log has CW = clog2(UNIFORM_BITS+1) normalize stages and
// the root has NI stages. The 30 squaring stages of the log, the rate
// multiplier and the bit-per-stage root set the radius path; the angle is
// delayed so its 31-stage CORDIC lands in the same cycle.
// Reset clears all valid bits and loads mean 0 and deviation 1.0.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// o_s_tready drops in the same cycle; nothing is lost or repeated.
module box_muller_gaussian_core #(
    parameter int UNIFORM_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [31:0]                           i_cfg_wdata,
    // input stream
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata: uniform_radius, uniform_angle, zero pad
    input  logic [((2*UNIFORM_BITS+7)/8)*8-1:0]   i_s_tdata,
    // tuser: pick_sine
    input  logic                                  i_s_tuser,
    // output stream
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // tdata: sample
    output logic [31:0]                           o_m_tdata,
    // tuser: saturated
    output logic                                  o_m_tuser
);
    localparam int UB   = UNIFORM_BITS;
    localparam int CW   = $clog2(UB + 1);
    localparam int TW   = CW + 30;
    localparam int RW   = TW + 1;
    localparam int SV   = RW + 18;
    localparam int NI   = (SV + (SV % 2)) / 2;
    localparam int KW   = 28;
    localparam int TLO  = 18;
    localparam int THI  = TW - TLO;
    localparam int RSW  = TW + KW + 1;
    localparam int DLY  = CW + NI + 4;
    localparam int AW   = (UB > 32) ? UB : 32;
    localparam int XW   = bmg_pkg::CORDIC_W;
    localparam int MW   = bmg_pkg::MAG_W;
    localparam int PW   = NI + MW;
    localparam int M2W  = bmg_pkg::MAG2_W;
    localparam int BPW  = M2W + 31;
    localparam int BW   = bmg_pkg::BIG_W;
    localparam int SMW  = bmg_pkg::SUM_W;

    logic                 w_adv;
    logic [31:0]          r_mean;
    logic [30:0]          r_std;

    // input split
    logic [UB-1:0]        w_u1;
    logic [UB-1:0]        w_u2;
    logic [AW-1:0]        w_ang_ext;
    logic [31:0]          w_ang;

    // radius path
    logic                 w_log_vld;
    logic [TW-1:0]        w_t;
    logic [TLO+KW-1:0]    r_plo;
    logic [THI+KW-1:0]    r_phi;
    logic                 r_m1_vld;
    logic [RSW-1:0]       w_rs_sum;
    logic [RW-1:0]        r_rsq;
    logic                 r_m2_vld;
    logic                 w_rad_vld;
    logic [NI-1:0]        w_rad;

    // angle path
    logic [31:0]          r_dang  [0:DLY-1];
    logic                 r_dpick [0:DLY-1];
    logic signed [XW-1:0] w_cos;
    logic signed [XW-1:0] w_sin;
    logic [1:0]           w_quad;
    logic                 w_pick;

    // tail
    logic                 w_use_sin;
    logic                 w_negate;
    logic signed [XW-1:0] w_trig;
    logic signed [XW-1:0] r_tv;
    logic [NI-1:0]        r_rad1;
    logic                 r_vld1;
    logic                 w_neg;
    logic [XW-1:0]        w_abs;
    logic [PW-1:0]        r_prod;
    logic                 r_neg2;
    logic                 r_vld2;
    logic [PW:0]          w_m2s;
    logic [M2W-1:0]       r_mag2;
    logic                 r_neg3;
    logic                 r_vld3;
    logic [BPW-1:0]       r_bp;
    logic                 r_neg4;
    logic                 r_vld4;
    logic [BPW:0]         w_bs;
    logic [SMW-1:0]       w_mean_x;
    logic [SMW-1:0]       w_big_x;
    logic [SMW-1:0]       w_sum;
    logic                 w_over;
    logic                 w_under;
    logic [31:0]          r_sample;
    logic                 r_sat;
    logic                 r_ovld;

    // Advance everything unless a finished word is waiting on the receiver
    assign w_adv      = !r_ovld || i_m_tready;
    assign o_s_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= 32'd0;
            r_std  <= 31'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bmg_pkg::CFG_MEAN: r_mean <= i_cfg_wdata;
                bmg_pkg::CFG_STD:  r_std  <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    assign w_u1 = i_s_tdata[UB-1:0];
    assign w_u2 = i_s_tdata[2*UB-1:UB];

    // Keep the top 32 angle bits; pad with zeros when the uniform is narrower
    assign w_ang_ext = AW'(w_u2) << (AW - UB);
    assign w_ang     = w_ang_ext[AW-1 -: 32];

    bmg_log2 #(.UNIFORM_BITS(UB)) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (i_s_tvalid),
        .i_u1    (w_u1),
        .o_vld   (w_log_vld),
        .o_t     (w_t)
    );

    // rsq = round(t * 2ln2), product split in two halves over two stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
        end else if (w_adv) begin
            r_m1_vld <= w_log_vld;
            r_m2_vld <= r_m1_vld;
        end
        if (w_adv) begin
            r_plo <= w_t[TLO-1:0] * bmg_pkg::TWO_LN2_Q27;
            r_phi <= w_t[TW-1:TLO] * bmg_pkg::TWO_LN2_Q27;
            r_rsq <= w_rs_sum[27 +: RW];
        end
    end

    assign w_rs_sum = (RSW'(r_phi) << TLO) + RSW'(r_plo) + (RSW'(1) << 26);

    bmg_sqrt #(.RSQ_W(RW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_m2_vld),
        .i_rsq   (r_rsq),
        .o_vld   (w_rad_vld),
        .o_root  (w_rad)
    );

    // Hold the angle back so the CORDIC finishes with the root
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dang[0]  <= w_ang;
            r_dpick[0] <= i_s_tuser;
        end
    end

    for (genvar d = 1; d < DLY; d++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dang[d]  <= r_dang[d-1];
                r_dpick[d] <= r_dpick[d-1];
            end
        end
    end

    bmg_cordic u_cordic (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_ang  (r_dang[DLY-1]),
        .i_pick (r_dpick[DLY-1]),
        .o_cos  (w_cos),
        .o_sin  (w_sin),
        .o_quad (w_quad),
        .o_pick (w_pick)
    );

    // Fold the quadrant back: sine picks s,c,-s,-c; cosine picks c,-s,-c,s
    assign w_use_sin = w_pick ? !w_quad[0] : w_quad[0];
    assign w_negate  = w_pick ? w_quad[1] : (w_quad[1] ^ w_quad[0]);
    assign w_trig    = w_use_sin ? w_sin : w_cos;

    assign w_neg = r_tv[XW-1];
    assign w_abs = w_neg ? XW'(-r_tv) : XW'(r_tv);
    assign w_m2s = (PW+1)'(r_prod) + ((PW+1)'(1) << 25);
    assign w_bs  = (BPW+1)'(r_bp) + ((BPW+1)'(1) << 27);

    assign w_mean_x = {{(SMW-32){r_mean[31]}}, r_mean};
    assign w_big_x  = SMW'(w_bs[28 +: BW]);
    assign w_sum    = r_neg4 ? (w_mean_x - w_big_x) : (w_mean_x + w_big_x);
    assign w_over   = !w_sum[SMW-1] && (w_sum[SMW-2:31] != '0);
    assign w_under  = w_sum[SMW-1] && (w_sum[SMW-2:31] != '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_ovld <= 1'b0;
        end else if (w_adv) begin
            r_vld1 <= w_rad_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_ovld <= r_vld4;
        end
        if (w_adv) begin
            r_tv   <= w_negate ? -w_trig : w_trig;
            r_rad1 <= w_rad;
            r_prod <= r_rad1 * w_abs[MW-1:0];
            r_neg2 <= w_neg;
            r_mag2 <= w_m2s[26 +: M2W];
            r_neg3 <= r_neg2;
            r_bp   <= r_mag2 * r_std;
            r_neg4 <= r_neg3;
            // clip to the signed 32-bit rails
            if (w_over) begin
                r_sample <= bmg_pkg::SAT_MAX;
            end else if (w_under) begin
                r_sample <= bmg_pkg::SAT_MIN;
            end else begin
                r_sample <= w_sum[31:0];
            end
            r_sat <= w_over || w_under;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = r_sample;
    assign o_m_tuser  = r_sat;

endmodule

// ===== rtl/bmg_checker.sv =====
module bmg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tuser
);

    // hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    // a flagged sample sits on a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> (o_m_tdata == 32'h7fff_ffff)
            || (o_m_tdata == 32'h8000_0000))
        else $error("saturation flag without a clipped sample");

    // an empty output stage never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // drop output valid after reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind box_muller_gaussian_core bmg_checker u_bmg_checker (.*);

// ===== tb/box_muller_gaussian_core_tb.sv =====
`timescale 1ns / 1ps

module box_muller_gaussian_core_tb;

    localparam int LATENCY    = 74;
    localparam int MAX_CYCLES = 400000;
    localparam int N_RANDOM   = 400;

    typedef struct packed {
        logic [31:0] u_radius;
        logic [31:0] u_angle;
        logic        pick_sine;
    } t_draw;

    typedef struct packed {
        logic [31:0] sample;
        logic        saturated;
    } t_sample;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;

    box_muller_gaussian_core #(.UNIFORM_BITS(32)) u_top (.*);

    // Predictor copy of the two registers
    logic signed [31:0] mean_q16;
    logic        [30:0] sigma_q16;

    t_draw   draw_q[$];
    t_sample gauss_q[$];
    int      n_errors;
    int      n_checked;
    int      n_sat;
    longint  cycle;
    int      hold_off;   // cycles left in a long receiver stall
    int      burst_left;
    int      gap_left;
    int      stall_phase;
    bit      feeding;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint asr64(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    // -log2(x / 2^32) in Q30 by normalize and repeated squaring
    function automatic longint unsigned nlog2_q30(longint unsigned x);
        int p;
        longint unsigned m, frac;
        p = 0;
        frac = 0;
        while (p < 63 && (x >> (p + 1)) != 0) p++;
        if (p >= 30) m = x >> (p - 30);
        else m = x << (30 - p);
        for (int i = 1; i <= 30; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m >>= 1;
                frac |= 64'd1 << (30 - i);
            end
        end
        return (longint'(32 - p) << 30) - frac;
    endfunction

    function automatic t_sample gauss_sample(t_draw d);
        longint unsigned t, rsq, radius, ang, frac, mag, big;
        longint x, y, z, nx, tv, sum, trig_c, trig_s;
        int quad;
        bit neg;
        t_sample r;
        t = nlog2_q30((64'd1 << 32) - longint'(d.u_radius));
        rsq = (t * bmg_pkg::TWO_LN2_Q27 + (64'd1 << 26)) >> 27;
        radius = isqrt64(rsq << 18);
        ang = d.u_angle;
        quad = int'((ang >> 30) & 3);
        frac = ang & 64'h3FFF_FFFF;
        z = longint'((frac * bmg_pkg::HALF_PI_Q30 + (64'd1 << 29)) >> 30);
        x = bmg_pkg::CORDIC_GAIN_Q30;
        y = 0;
        for (int i = 0; i < bmg_pkg::CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - asr64(y, i);
                y = y + asr64(x, i);
                z -= longint'(bmg_pkg::atan_q30(i));
            end else begin
                nx = x + asr64(y, i);
                y = y - asr64(x, i);
                z += longint'(bmg_pkg::atan_q30(i));
            end
            x = nx;
        end
        trig_c = x;
        trig_s = y;
        if (d.pick_sine)
            tv = (quad == 0) ? trig_s : (quad == 1) ? trig_c : (quad == 2) ? -trig_s : -trig_c;
        else
            tv = (quad == 0) ? trig_c : (quad == 1) ? -trig_s : (quad == 2) ? -trig_c : trig_s;
        neg = tv < 0;
        mag = neg ? longint'(-tv) : longint'(tv);
        mag = (radius * mag + (64'd1 << 25)) >> 26;
        big = (mag * longint'(sigma_q16) + (64'd1 << 27)) >> 28;
        sum = neg ? longint'(mean_q16) - longint'(big) : longint'(mean_q16) + longint'(big);
        r.saturated = 1'b0;
        if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            r.saturated = 1'b1;
        end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            r.saturated = 1'b1;
        end
        r.sample = sum[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("MISMATCH %s at cycle %0d: got %h want %h", what, cycle, got, want);
    endtask

    // Driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                gauss_q.push_back(gauss_sample(draw_q.pop_front()));
            end
            if (!(i_s_tvalid && !o_s_tready)) begin
                // previous word accepted or none offered: pick the next one
                if (draw_q.size() == 0 || !feeding) begin
                    i_s_tvalid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_s_tvalid <= 1'b0;
                end else begin
                    i_s_tvalid <= 1'b1;
                    {i_s_tdata[31:0], i_s_tdata[63:32], i_s_tuser} <= draw_q[0];
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end
            end
        end
    end

    // Receiver: own stall pattern, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready  <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_m_tready <= 1'b0;
            end else if (stall_phase[8]) begin
                i_m_tready <= 1'b1;              // stretch with no stalls
            end else begin
                i_m_tready <= ($urandom_range(0, 99) < 65);
            end
        end
    end

    // Monitor: compare each accepted word against the oldest prediction
    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (gauss_q.size() == 0) begin
                report_mismatch("unexpected word", o_m_tdata, 32'h0);
            end else begin
                want = gauss_q.pop_front();
                n_checked++;
                if (want.saturated) n_sat++;
                if (o_m_tdata !== want.sample)
                    report_mismatch("sample", o_m_tdata, want.sample);
                if (o_m_tuser !== want.saturated)
                    report_mismatch("saturated", {31'd0, o_m_tuser}, {31'd0, want.saturated});
            end
        end
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLES) begin
            $display("Timeout after %0d cycles", cycle);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bmg_pkg::CFG_MEAN) mean_q16 = val;
        else sigma_q16 = val[30:0];
    endtask

    task automatic add_draw(logic [31:0] ur, logic [31:0] ua, logic pk);
        draw_q.push_back({ur, ua, pk});
    endtask

    // Release the queued words and wait until every prediction has come back
    task automatic drain();
        feeding = 1'b1;
        while (draw_q.size() != 0 || gauss_q.size() != 0) @(posedge i_clk);
        feeding = 1'b0;
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic random_draws(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: add_draw(32'($urandom_range(0, 255)), $urandom,
                            1'($urandom_range(0, 1)));
                1: add_draw(32'hFFFF_FFFF - 32'($urandom_range(0, 255)), $urandom,
                            1'($urandom_range(0, 1)));
                2: add_draw($urandom,
                            {2'($urandom_range(0, 3)), 30'd0} + 32'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)));
                default: add_draw($urandom, $urandom, 1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = bmg_pkg::CFG_MEAN;
        i_cfg_wdata = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;
        n_errors = 0;
        n_checked = 0;
        n_sat = 0;
        cycle = 0;
        hold_off = 0;
        feeding = 1'b0;
        mean_q16 = 32'sd0;
        sigma_q16 = 31'd65536;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, field extremes and quadrant edges
        add_draw(32'd0, 32'd0, 1'b0);
        add_draw(32'd0, 32'hFFFF_FFFF, 1'b1);
        add_draw(32'hFFFF_FFFF, 32'd0, 1'b0);
        add_draw(32'hFFFF_FFFF, 32'd0, 1'b1);
        add_draw(32'hFFFF_FFFF, 32'h4000_0000, 1'b0);
        add_draw(32'hFFFF_FFFF, 32'h4000_0000, 1'b1);
        add_draw(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        add_draw(32'hFFFF_FFFF, 32'hC000_0000, 1'b1);
        add_draw(32'h8000_0000, 32'h3FFF_FFFF, 1'b0);
        add_draw(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        add_draw(32'h0000_0001, 32'hBFFF_FFFF, 1'b0);
        add_draw(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        add_draw(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        drain();

        // Extreme settings: saturation both ways
        write_reg(bmg_pkg::CFG_STD, 32'h7FFF_FFFF);
        write_reg(bmg_pkg::CFG_MEAN, 32'h7FFF_0000);
        add_draw(32'hFFFF_FFFF, 32'd0, 1'b0);
        add_draw(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        add_draw(32'd0, 32'd0, 1'b1);
        drain();
        write_reg(bmg_pkg::CFG_MEAN, 32'h8000_0000);
        add_draw(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        add_draw(32'hFFFF_FFFF, 32'd0, 1'b0);
        add_draw(32'hF000_0000, 32'h4000_0000, 1'b1);
        drain();
        write_reg(bmg_pkg::CFG_STD, 32'h0);
        write_reg(bmg_pkg::CFG_MEAN, 32'h7FFF_FFFF);
        add_draw(32'hFFFF_FFFF, 32'd0, 1'b0);
        add_draw(32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
        drain();

        // Random phases, each under its own settings; the first one with a long stall
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(bmg_pkg::CFG_MEAN, $urandom);
            write_reg(bmg_pkg::CFG_STD,
                      (ph == 3) ? 32'hFFFF_FFFF : ($urandom >> $urandom_range(1, 16)));
            random_draws(N_RANDOM / 4);
            if (ph == 0) hold_off = 300;
            drain();
        end

        $display("Covered %0d samples, %0d saturated, over several mean/deviation settings",
                 n_checked, n_sat);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bmg_pkg.sv
rtl/bmg_log2.sv
rtl/bmg_sqrt.sv
rtl/bmg_cordic.sv
rtl/box_muller_gaussian_core.sv
rtl/bmg_checker.sv
tb/box_muller_gaussian_core_tb.sv
